### src/sfm_pkg.sv
// Shared types, sizing constants and helper functions for the substring first-match finder.
// Used by sfm_scan, sfm_outq and substring_first_match_finder_core; depends on nothing.
package sfm_pkg;

   localparam int MAX_PATTERN   = 16;
   localparam int POSITION_BITS = 16;

   // Fixed field widths of the register map and the result item.
   localparam int LENGTH_REG_BITS = 5;
   localparam int START_BITS      = 16;
   localparam int OUT_POS_BITS    = 16;
   localparam int PATTERN_BITS    = 128;
   localparam int PATTERN_BYTES   = PATTERN_BITS / 8;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_INDEX_BITS  = 3;

   // Byte counter holds up to 2^POSITION_BITS + 1.
   localparam int COUNT_BITS = POSITION_BITS + 2;
   localparam logic [COUNT_BITS-1:0] TEXT_CAP = COUNT_BITS'(1) << POSITION_BITS;

   localparam int LEN_BITS   = ($clog2(MAX_PATTERN + 1) > LENGTH_REG_BITS) ?
                               $clog2(MAX_PATTERN + 1) : LENGTH_REG_BITS;
   localparam int WIN_IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int WIDE_BITS  = ((COUNT_BITS > START_BITS) ? COUNT_BITS : START_BITS) + 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PATTERN_LOW    = 3'd1,
      REG_PATTERN_HIGH   = 3'd2,
      REG_START_POSITION = 3'd3
   } reg_index_type;

   typedef struct packed {
      logic [LENGTH_REG_BITS-1:0] pattern_length;
      logic [PATTERN_BITS-1:0]    pattern;
      logic [START_BITS-1:0]      start_position;
   } cfg_type;

   typedef struct packed {
      logic                    found;
      logic [OUT_POS_BITS-1:0] match_position;
      logic                    too_long;
   } result_type;

   // Pattern byte k; bytes past the two pattern registers read as zero.
   function automatic logic [7:0] pattern_byte(input logic [PATTERN_BITS-1:0] pat,
                                                input int k);
      logic [7:0] b;
      b = 8'd0;
      if (k < PATTERN_BYTES) begin
         b = pat[8*k +: 8];
      end
      return b;
   endfunction

   // Pattern length in use, clamped to the window depth.
   function automatic logic [LEN_BITS-1:0] used_length(
         input logic [LENGTH_REG_BITS-1:0] len);
      logic [LEN_BITS-1:0] n;
      n = LEN_BITS'(len);
      if (n > LEN_BITS'(MAX_PATTERN)) begin
         n = LEN_BITS'(MAX_PATTERN);
      end
      return n;
   endfunction

endpackage

### src/substring_first_match_finder_core.sv
// Top level of the substring first-match finder: register file, stream scan and result queue.
// Depends on sfm_pkg, sfm_scan and sfm_outq.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | text_byte, carries_byte, is_last
//   rsp     | out       | rsp_valid / rsp_stall   | found, match_position, too_long
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// One input transfer is taken every cycle while req_stall is low. Each byte is shifted into
// the window and compared against the whole pattern in the same cycle. The result of the
// transfer that carries the last flag is registered in the result register or the skid entry.
// Reset is synchronous and clears the stream state and restores the register defaults.
// The result side has a register plus one skid entry; req_stall rises only when both
// hold results, and drops once the skid entry has moved into the result register.
module substring_first_match_finder_core (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_text_byte,
   input  logic                                 req_carries_byte,
   input  logic                                 req_is_last,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [sfm_pkg::OUT_POS_BITS-1:0]     rsp_match_position,
   output logic                                 rsp_too_long,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sfm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sfm_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   sfm_pkg::cfg_type    cfg_ff, cfg_in;
   logic                take;
   logic                res_valid;
   sfm_pkg::result_type res;
   sfm_pkg::result_type out_data;
   logic                full;

   // Registers are always writable; software must write them only while the block is idle (not enforced here).
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (sfm_pkg::reg_index_type'(csr_index))
            sfm_pkg::REG_PATTERN_LENGTH:
               cfg_in.pattern_length = csr_data[sfm_pkg::LENGTH_REG_BITS-1:0];
            sfm_pkg::REG_PATTERN_LOW:
               cfg_in.pattern[63:0] = csr_data;
            sfm_pkg::REG_PATTERN_HIGH:
               cfg_in.pattern[127:64] = csr_data;
            sfm_pkg::REG_START_POSITION:
               cfg_in.start_position = csr_data[sfm_pkg::START_BITS-1:0];
            default: begin
               // Unknown register indexes are ignored.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_length <= sfm_pkg::LENGTH_REG_BITS'(1);
         cfg_ff.pattern        <= '0;
         cfg_ff.start_position <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The skid entry in the result queue is the only source of backpressure.
   assign req_stall = full;
   assign take      = req_valid && !req_stall;

   sfm_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .text_byte    (req_text_byte),
      .carries_byte (req_carries_byte),
      .is_last      (req_is_last),
      .cfg          (cfg_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   sfm_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_found          = out_data.found;
   assign rsp_match_position = out_data.match_position;
   assign rsp_too_long       = out_data.too_long;

   // Backpressure only comes from a waiting result.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall high with no result pending");

   // A result reported as not found always carries a zero position.
   a_not_found_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_position == '0))
      else $error("not-found result with nonzero position");

   // A closing transfer into an empty result register shows up in the next cycle.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_is_last && !rsp_valid) |=> rsp_valid)
      else $error("closing transfer produced no result");

endmodule

### src/sfm_scan.sv
// Stream state of the finder: byte window, byte counter, first-match record and result build.
// Depends on sfm_pkg.
module sfm_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          text_byte,
   input  logic                carries_byte,
   input  logic                is_last,
   input  sfm_pkg::cfg_type    cfg,
   output logic                res_valid,
   output sfm_pkg::result_type res
);

   logic [7:0]                        window_ff [sfm_pkg::MAX_PATTERN];
   logic [7:0]                        window_in [sfm_pkg::MAX_PATTERN];
   logic [sfm_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic                              seen_ff, seen_in;
   logic [sfm_pkg::POSITION_BITS-1:0] first_ff, first_in;

   logic [7:0]                        shifted [sfm_pkg::MAX_PATTERN];
   logic [sfm_pkg::LEN_BITS-1:0]      n;
   logic                              capped;
   logic [sfm_pkg::COUNT_BITS-1:0]    count_next;
   logic [sfm_pkg::WIDE_BITS-1:0]     start_wide;
   logic [sfm_pkg::WIDE_BITS-1:0]     n_wide;
   logic [sfm_pkg::WIDE_BITS-1:0]     cnt_wide;
   logic [sfm_pkg::WIDE_BITS-1:0]     len_wide;
   logic [sfm_pkg::WIDE_BITS-1:0]     where_wide;
   logic                              bytes_equal;
   logic                              hit;
   logic                              seen_next;
   logic [sfm_pkg::POSITION_BITS-1:0] first_next;

   assign n      = sfm_pkg::used_length(cfg.pattern_length);
   assign capped = (count_ff >= sfm_pkg::TEXT_CAP);

   always_comb begin
      shifted[0] = text_byte;
      for (int i = 1; i < sfm_pkg::MAX_PATTERN; i++) begin
         shifted[i] = window_ff[i-1];
      end
   end

   // Byte k of the pattern lines up with window entry n-1-k.
   always_comb begin
      int j;
      bytes_equal = 1'b1;
      for (int k = 0; k < sfm_pkg::MAX_PATTERN; k++) begin
         j = int'(n) - 1 - k;
         if (k < int'(n)) begin
            if (shifted[j[sfm_pkg::WIN_IDX_BITS-1:0]] !=
                sfm_pkg::pattern_byte(cfg.pattern, k)) begin
               bytes_equal = 1'b0;
            end
         end
      end
   end

   always_comb begin
      count_next = count_ff;
      if (carries_byte) begin
         count_next = capped ? (sfm_pkg::TEXT_CAP + 1'b1) : (count_ff + 1'b1);
      end
   end

   assign start_wide = sfm_pkg::WIDE_BITS'(cfg.start_position);
   assign n_wide     = sfm_pkg::WIDE_BITS'(n);
   assign cnt_wide   = sfm_pkg::WIDE_BITS'(count_next);
   assign where_wide = cnt_wide - n_wide;

   assign hit = carries_byte && !capped && !seen_ff && (n != '0) &&
                (cnt_wide >= n_wide) && (where_wide >= start_wide) && bytes_equal;

   assign seen_next  = seen_ff || hit;
   assign first_next = hit ? where_wide[sfm_pkg::POSITION_BITS-1:0] : first_ff;

   assign len_wide = (count_next > sfm_pkg::TEXT_CAP) ?
                     sfm_pkg::WIDE_BITS'(sfm_pkg::TEXT_CAP) : cnt_wide;

   always_comb begin
      logic [sfm_pkg::WIDE_BITS+sfm_pkg::POSITION_BITS-1:0] pos_ext;
      pos_ext = '0;
      res.too_long = (count_next > sfm_pkg::TEXT_CAP);
      if (n == '0) begin
         res.found = (start_wide <= len_wide);
         pos_ext   = res.found ? (sfm_pkg::WIDE_BITS + sfm_pkg::POSITION_BITS)'(start_wide)
                               : '0;
      end else begin
         res.found = seen_next;
         pos_ext   = seen_next ? (sfm_pkg::WIDE_BITS + sfm_pkg::POSITION_BITS)'(first_next)
                               : '0;
      end
      res.match_position = pos_ext[sfm_pkg::OUT_POS_BITS-1:0];
   end

   assign res_valid = take && is_last;

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      first_in  = first_ff;
      if (take) begin
         if (is_last) begin
            for (int i = 0; i < sfm_pkg::MAX_PATTERN; i++) begin
               window_in[i] = 8'd0;
            end
            count_in = '0;
            seen_in  = 1'b0;
            first_in = '0;
         end else begin
            if (carries_byte && !capped) begin
               window_in = shifted;
            end
            count_in = count_next;
            seen_in  = seen_next;
            first_in = first_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sfm_pkg::MAX_PATTERN; i++) begin
            window_ff[i] <= 8'd0;
         end
         count_ff <= '0;
         seen_ff  <= 1'b0;
         first_ff <= '0;
      end else begin
         window_ff <= window_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
         first_ff  <= first_in;
      end
   end

endmodule

### src/sfm_outq.sv
// Result register with one skid entry, so a finished result can wait while input goes on.
// Depends on sfm_pkg.
module sfm_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sfm_pkg::result_type push_data,
   output logic                full,
   output logic                out_valid,
   output sfm_pkg::result_type out_data,
   input  logic                out_stall
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   sfm_pkg::result_type out_data_ff, out_data_in;
   sfm_pkg::result_type skid_data_ff, skid_data_in;
   logic                pop;

   assign pop = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // Input side is stalled while the skid entry is in use.
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
